### rtl/core/mi3_pkg.sv
// Shared constants, cofactor index table and flag struct for the 3x3 inverse core.
// No dependencies.
package mi3_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int N_ELEM         = 9;

    // Element indexes {p, q, r, s}: inverse numerator (r,c) = a[p]*a[q] - a[r]*a[s]
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 7, 5}, '{1, 8, 7, 2}, '{1, 5, 4, 2},
        '{3, 8, 6, 5}, '{0, 8, 6, 2}, '{0, 5, 3, 2},
        '{3, 7, 6, 4}, '{0, 7, 6, 1}, '{0, 4, 3, 1}
    };
    // Entries whose 2x2 minor is negated
    localparam logic [N_ELEM-1:0] COF_NEG = 9'b010101010;

    // Determinant status handed from the front end
    typedef struct packed {
        logic singular;
        logic dneg;
    } mi3_flags_t;

endpackage

### rtl/core/matrix3_inverse_core.sv
// Top level of the 3x3 fixed-point matrix inverse core.
// Depends on mi3_pkg, mi3_front, mi3_lane, mi3_merge.
//
// Usage:
//  - One item on the s_ channel is a full 3x3 matrix (a00..a22, signed
//    Q(E-F).F); one item on the m_ channel is the inverse (b00..b22) with
//    singular and overflow flags in m_tuser.
//  - Throughput: one matrix per cycle while s_tready is high. Nine
//    division lanes run in parallel, each a pipeline that resolves one
//    quotient bit per stage. Pipeline: 6 front-end stages, ELEM_WIDTH + 4
//    lane stages, merge, output register.
//  - Singular matrix: all b fields zero, singular set, overflow clear.
//  - Saturation: an element beyond the output range clamps and sets overflow.
//  - Reset (aresetn low, synchronous) empties the pipeline and output register.
//  - Stall: the pipeline keeps accepting while a result waits in the output
//    register; it holds only when its last stage is full as well, and then
//    s_tready drops until m_tready returns.
module matrix3_inverse_core import mi3_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 from bit 0 up, zero pad
    input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // b00, b01, b02, b10, b11, b12, b20, b21, b22 from bit 0 up, zero pad
    output logic [((9*ELEM_WIDTH+7)/8)*8-1:0] m_tdata,
    // singular (bit 0), overflow (bit 1)
    output logic [1:0]            m_tuser
);
    localparam int E    = ELEM_WIDTH;
    localparam int TW   = ((9*E+7)/8)*8;
    localparam int LLAT = E + 4;
    localparam int DEPTH = 6 + LLAT + 1;

    logic                 en;
    logic [DEPTH-1:0]     vld_reg;
    logic                 out_vld_reg;
    logic [TW-1:0]        out_data_reg;
    logic [1:0]           out_user_reg;
    logic signed [E-1:0]  a [N_ELEM];
    logic signed [2*E:0]  cof [N_ELEM];
    logic [3*E+2:0]       dmag;
    mi3_flags_t           flags;
    logic [LLAT-1:0]      sing_dly_reg;
    logic [E-1:0]         lane_b [N_ELEM];
    logic [N_ELEM-1:0]    lane_sat;
    logic [E-1:0]         mrg_b [N_ELEM];
    logic                 mrg_singular, mrg_overflow;
    logic [TW-1:0]        mrg_data;

    // Whole pipeline advances unless the last stage and the output are both full
    assign en       = !(vld_reg[DEPTH-1] && out_vld_reg && !m_tready);
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < N_ELEM; i++)
            a[i] = $signed(s_tdata[i*E +: E]);
    end

    mi3_front #(.E(E)) u_front (
        .aclk  (aclk),
        .en    (en),
        .a     (a),
        .cof   (cof),
        .dmag  (dmag),
        .flags (flags)
    );

    for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
        mi3_lane #(.E(E), .F(FRAC_BITS)) u_lane (
            .aclk (aclk),
            .en   (en),
            .cof  (cof[i]),
            .dmag (dmag),
            .dneg (flags.dneg),
            .b    (lane_b[i]),
            .sat  (lane_sat[i])
        );
    end

    // Singular flag travels alongside the lanes
    always_ff @(posedge aclk) begin
        if (en)
            sing_dly_reg <= {sing_dly_reg[LLAT-2:0], flags.singular};
    end

    mi3_merge #(.E(E)) u_merge (
        .aclk        (aclk),
        .en          (en),
        .b_in        (lane_b),
        .sat_in      (lane_sat),
        .singular_in (sing_dly_reg[LLAT-1]),
        .b_out       (mrg_b),
        .singular    (mrg_singular),
        .overflow    (mrg_overflow)
    );

    always_comb begin
        mrg_data = '0;
        for (int i = 0; i < N_ELEM; i++)
            mrg_data[i*E +: E] = mrg_b[i];
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (vld_reg[DEPTH-1] && en) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (vld_reg[DEPTH-1] && en) begin
            out_data_reg <= mrg_data;
            out_user_reg <= {mrg_overflow, mrg_singular};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // A singular result carries zero data and no overflow
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("singular result with nonzero data");

    // Input side stalls only while a result waits and the last stage is full
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // Nothing leaves right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

### rtl/core/mi3_front.sv
// Front end: 2x2 minors, cofactors and determinant, six pipeline stages.
// Depends on mi3_pkg.
module mi3_front import mi3_pkg::*; #(
    parameter int E = ELEM_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [E-1:0]    a [N_ELEM],
    output logic signed [2*E:0]    cof [N_ELEM],
    output logic [3*E+2:0]         dmag,
    output mi3_flags_t             flags
);
    localparam int CW = 2*E + 1;
    localparam int DW = 3*E + 3;

    logic signed [2*E-1:0] pp_reg [N_ELEM];
    logic signed [2*E-1:0] pq_reg [N_ELEM];
    logic signed [E-1:0]   a1_reg [3];
    logic signed [E-1:0]   a2_reg [3];
    logic signed [CW-1:0]  cof_reg [N_ELEM];
    logic signed [CW-1:0]  cof_dly_reg [4][N_ELEM];
    logic signed [2*E:0]   plo_reg [3];
    logic signed [2*E:0]   phi_reg [3];
    logic signed [DW-1:0]  term_reg [3];
    logic signed [DW-1:0]  det_reg;
    logic [DW-1:0]         dmag_reg;
    mi3_flags_t            flags_reg;
    logic signed [DW-1:0]  det_next;

    // Stage 1: products of the minors; stage 2: cofactors
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N_ELEM; i++) begin
                pp_reg[i] <= a[COF_IDX[i][0]] * a[COF_IDX[i][1]];
                pq_reg[i] <= a[COF_IDX[i][2]] * a[COF_IDX[i][3]];
                if (COF_NEG[i])
                    cof_reg[i] <= CW'(pq_reg[i]) - CW'(pp_reg[i]);
                else
                    cof_reg[i] <= CW'(pp_reg[i]) - CW'(pq_reg[i]);
            end
            for (int j = 0; j < 3; j++) begin
                a1_reg[j] <= a[j];
                a2_reg[j] <= a1_reg[j];
            end
        end
    end

    // Stage 3: split products along column 0 cofactors; stage 4: recombine
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                plo_reg[j] <= a2_reg[j] * $signed({1'b0, cof_reg[3*j][E-1:0]});
                phi_reg[j] <= a2_reg[j] * $signed(cof_reg[3*j][CW-1:E]);
                term_reg[j] <= (DW'(phi_reg[j]) <<< E) + DW'(plo_reg[j]);
            end
        end
    end

    assign det_next = term_reg[0] + term_reg[1] + term_reg[2];

    // Stage 5: determinant; stage 6: magnitude and flags
    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg            <= det_next;
            dmag_reg           <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            flags_reg.dneg     <= det_reg[DW-1];
            flags_reg.singular <= (det_reg == '0);
            cof_dly_reg[0]     <= cof_reg;
            for (int k = 1; k < 4; k++)
                cof_dly_reg[k] <= cof_dly_reg[k-1];
        end
    end

    assign cof   = cof_dly_reg[3];
    assign dmag  = dmag_reg;
    assign flags = flags_reg;

endmodule

### rtl/core/mi3_lane.sv
// One division lane: rounded, saturated cofactor * 2^(2F) / det, E+4 stages.
// Depends on mi3_pkg.
module mi3_lane import mi3_pkg::*; #(
    parameter int E = ELEM_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [2*E:0]  cof,
    input  logic [3*E+2:0]       dmag,
    input  logic                 dneg,
    output logic [E-1:0]         b,
    output logic                 sat
);
    localparam int CW = 2*E + 1;
    localparam int DW = 3*E + 3;
    localparam int WA = 2*E + 2*F + 3;
    localparam int WB = 4*E + 5;
    localparam int W  = (WA > WB) ? WA : WB;
    localparam logic [E:0] LIM_POS = {2'b00, {(E-1){1'b1}}};
    localparam logic [E:0] LIM_NEG = {2'b01, {(E-1){1'b0}}};

    logic [W-1:0] n_reg, dv_reg;
    logic         neg_reg;
    logic [W-1:0] r_reg  [E+2];
    logic [W-1:0] d_reg  [E+2];
    logic [E:0]   q_reg  [E+2];
    logic         s_reg  [E+2];
    logic         big_reg[E+2];
    logic [E-1:0] b_reg;
    logic         sat_reg;
    logic [CW-1:0] cmag;
    logic [E:0]   lim, mag, bneg;
    logic         over;

    assign cmag = cof[CW-1] ? CW'(-cof) : CW'(cof);

    // Prep: numerator with half divisor for rounding, doubled divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg   <= (W'(cmag) << (2*F + 1)) + W'(dmag);
            dv_reg  <= W'(dmag) << 1;
            neg_reg <= cof[CW-1] ^ dneg;
        end
    end

    // Range check: a quotient of E+2 bits or more saturates anyway
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= n_reg;
            d_reg[0]   <= dv_reg;
            q_reg[0]   <= '0;
            s_reg[0]   <= neg_reg;
            big_reg[0] <= (n_reg >= (dv_reg << (E + 1)));
        end
    end

    // Restoring division, one quotient bit per stage, MSB first
    for (genvar j = 0; j <= E; j++) begin : g_step
        localparam int K = E - j;
        logic [W-1:0] sub;
        logic         ge;
        assign sub = d_reg[j] << K;
        assign ge  = (r_reg[j] >= sub);
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j+1]   <= ge ? (r_reg[j] - sub) : r_reg[j];
                q_reg[j+1]   <= q_reg[j] | ((E+1)'(ge) << K);
                d_reg[j+1]   <= d_reg[j];
                s_reg[j+1]   <= s_reg[j];
                big_reg[j+1] <= big_reg[j];
            end
        end
    end

    // Saturate and apply sign
    always_comb begin
        lim  = s_reg[E+1] ? LIM_NEG : LIM_POS;
        over = big_reg[E+1] || (q_reg[E+1] > lim);
        mag  = over ? lim : q_reg[E+1];
        bneg = (E+1)'(0) - mag;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_reg   <= s_reg[E+1] ? bneg[E-1:0] : mag[E-1:0];
            sat_reg <= over;
        end
    end

    assign b   = b_reg;
    assign sat = sat_reg;

endmodule

### rtl/core/mi3_merge.sv
// Merge stage: combines the nine lane results with the singular flag.
// Depends on mi3_pkg.
module mi3_merge import mi3_pkg::*; #(
    parameter int E = ELEM_WIDTH_DEF
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [E-1:0]  b_in [N_ELEM],
    input  logic [N_ELEM-1:0] sat_in,
    input  logic          singular_in,
    output logic [E-1:0]  b_out [N_ELEM],
    output logic          singular,
    output logic          overflow
);
    logic [E-1:0] b_reg [N_ELEM];
    logic         singular_reg, overflow_reg;

    // Singular matrix forces zeros and clears overflow
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N_ELEM; i++)
                b_reg[i] <= singular_in ? '0 : b_in[i];
            singular_reg <= singular_in;
            overflow_reg <= (|sat_in) && !singular_in;
        end
    end

    assign b_out    = b_reg;
    assign singular = singular_reg;
    assign overflow = overflow_reg;

endmodule

### bench/tb.sv
// Self-checking bench for matrix3_inverse_core: directed matrices, then random ones.
// Depends on mi3_pkg and the core RTL; an in-bench predictor gives the expected inverse.
module tb;
    import mi3_pkg::*;

    localparam int EW = ELEM_WIDTH_DEF;
    localparam int DW = ((9 * EW + 7) / 8) * 8;
    localparam int ONE = 32'h0001_0000;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = EW + 30;
    localparam int N_RANDOM = 400;

    typedef struct {
        logic [DW-1:0] data;
        logic [1:0]    user;
    } inverse_t;

    typedef struct {
        logic [DW-1:0] mat;
        bit            known;
        logic [DW-1:0] exp_data;
        logic [1:0]    exp_user;
    } vector_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic [1:0]    m_tuser;

    inverse_t expected_inv[$];
    int       errors = 0;
    int       n_checked = 0;
    int       n_singular = 0;
    int       n_overflow = 0;
    int       idle_cycles = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    matrix3_inverse_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Exact cofactor inverse, rounded half away from zero, saturated to 32 bits
    function automatic inverse_t invert(logic [DW-1:0] d);
        logic signed [255:0] a[9];
        logic signed [255:0] cof[9];
        logic signed [255:0] det;
        logic [255:0] dmag, cmag, q, lim;
        bit neg, sat;
        inverse_t r;
        sat = 1'b0;
        r.data = '0;
        for (int i = 0; i < 9; i++) a[i] = {{(256-EW){d[i*EW+EW-1]}}, d[i*EW +: EW]};
        cof[0] = a[4] * a[8] - a[7] * a[5];
        cof[1] = a[7] * a[2] - a[1] * a[8];
        cof[2] = a[1] * a[5] - a[4] * a[2];
        cof[3] = a[6] * a[5] - a[3] * a[8];
        cof[4] = a[0] * a[8] - a[6] * a[2];
        cof[5] = a[3] * a[2] - a[0] * a[5];
        cof[6] = a[3] * a[7] - a[6] * a[4];
        cof[7] = a[6] * a[1] - a[0] * a[7];
        cof[8] = a[0] * a[4] - a[3] * a[1];
        det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
        if (det == 0) begin
            r.user = 2'b01;
            return r;
        end
        dmag = det[255] ? -det : det;
        for (int i = 0; i < 9; i++) begin
            cmag = cof[i][255] ? -cof[i] : cof[i];
            neg = cof[i][255] ^ det[255];
            q = ((cmag << (2 * FRAC_BITS_DEF + 1)) + dmag) / (dmag << 1);
            lim = neg ? (256'd1 << (EW - 1)) : ((256'd1 << (EW - 1)) - 1);
            if (q > lim) begin
                q = lim;
                sat = 1'b1;
            end
            q = neg ? -q : q;
            r.data[i*EW +: EW] = q[EW-1:0];
        end
        r.user = {sat, 1'b0};
        return r;
    endfunction

    function automatic logic [DW-1:0] pack9(int e0, int e1, int e2, int e3, int e4,
                                            int e5, int e6, int e7, int e8);
        return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
    endfunction

    function automatic logic [DW-1:0] diag(int v);
        return pack9(v, 0, 0, 0, v, 0, 0, 0, v);
    endfunction

    // Random matrix: small range, full range, singular or diagonal
    function automatic logic [DW-1:0] random_matrix();
        logic [DW-1:0] m;
        int sel;
        sel = $urandom_range(99);
        for (int i = 0; i < 9; i++) begin
            if (sel < 55) m[i*EW +: EW] = $urandom_range(8 * ONE) - 4 * ONE;
            else m[i*EW +: EW] = $urandom;
        end
        if (sel >= 75 && sel < 85) begin
            // repeated row
            m[6*EW +: 3*EW] = m[0 +: 3*EW];
        end else if (sel >= 85 && sel < 90) begin
            m[3*EW +: 3*EW] = '0;
        end else if (sel >= 90) begin
            m = diag(0);
            for (int i = 0; i < 3; i++) m[i*4*EW +: EW] = $urandom_range(4 * ONE) - 2 * ONE;
        end
        return m;
    endfunction

    // Present one matrix and record its expected inverse once accepted
    task automatic send_matrix(vector_t v);
        inverse_t e;
        // sender gaps, idle while a random draw falls below send_idle_pct
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= v.mat;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (v.known) begin
            e.data = v.exp_data;
            e.user = v.exp_user;
        end else begin
            e = invert(v.mat);
        end
        expected_inv.push_back(e);
    endtask

    // Receiver stalls and result check
    always @(posedge aclk) begin
        inverse_t e;
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                if (expected_inv.size() == 0) begin
                    $display("%0t: unexpected item data=%h user=%b", $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    e = expected_inv.pop_front();
                    n_checked++;
                    if (e.user[0]) n_singular++;
                    if (e.user[1]) n_overflow++;
                    for (int i = 0; i < 9; i++) begin
                        if (m_tdata[i*EW +: EW] !== e.data[i*EW +: EW]) begin
                            $display("%0t: b%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                                     e.data[i*EW +: EW], m_tdata[i*EW +: EW]);
                            errors++;
                        end
                    end
                    if (m_tuser[0] !== e.user[0]) begin
                        $display("%0t: singular expected %b actual %b", $time, e.user[0],
                                 m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== e.user[1]) begin
                        $display("%0t: overflow expected %b actual %b", $time, e.user[1],
                                 m_tuser[1]);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d items outstanding", $time,
                     expected_inv.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        vector_t dir[$];
        vector_t v;
        int phase;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; known answers typed where obvious
        v.known = 1'b1;
        v.mat = diag(ONE); v.exp_data = diag(ONE); v.exp_user = 2'b00; dir.push_back(v);
        v.mat = diag(-ONE); v.exp_data = diag(-ONE); v.exp_user = 2'b00; dir.push_back(v);
        v.mat = diag(2 * ONE); v.exp_data = diag(ONE / 2); v.exp_user = 2'b00;
        dir.push_back(v);
        v.mat = '0; v.exp_data = '0; v.exp_user = 2'b01; dir.push_back(v);
        v.mat = {9{32'h7fff_ffff}}; v.exp_data = '0; v.exp_user = 2'b01; dir.push_back(v);
        v.mat = {9{32'h8000_0000}}; v.exp_data = '0; v.exp_user = 2'b01; dir.push_back(v);
        v.mat = diag(1); v.exp_data = diag(32'h7fff_ffff); v.exp_user = 2'b10;
        dir.push_back(v);
        v.mat = diag(-1); v.exp_data = diag(32'h8000_0000); v.exp_user = 2'b10;
        dir.push_back(v);
        v.known = 1'b0;
        v.mat = diag(3 * ONE); dir.push_back(v);
        v.mat = diag(32'h7fff_ffff); dir.push_back(v);
        v.mat = diag(32'h8000_0000); dir.push_back(v);
        v.mat = pack9(2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE); dir.push_back(v);
        v.mat = pack9(0, ONE, 0, 0, 0, ONE, ONE, 0, 0); dir.push_back(v);
        v.mat = pack9(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, 0,
                      0, 0, ONE); dir.push_back(v);
        v.mat = pack9(ONE, 2, 3, 4, ONE, 6, 7, 8, ONE); dir.push_back(v);
        v.mat = pack9(3, 0, 0, 0, 3, 0, 0, 0, 3 * ONE); dir.push_back(v);
        v.mat = {32'hffff_ffff, {8{32'h0}}} | diag(32'hffff_ffff); dir.push_back(v);
        v.mat = {9{32'h5555_aaaa}} ^ diag(32'hffff_ffff); dir.push_back(v);

        send_idle_pct = 37;
        recv_idle_pct = 48;
        foreach (dir[i]) send_matrix(dir[i]);

        // Random part in three idling phases
        v.known = 1'b0;
        for (int n = 0; n < N_RANDOM; n++) begin
            phase = n * 3 / N_RANDOM;
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 48 : 0;
            recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 37 : 0;
            v.mat = random_matrix();
            send_matrix(v);
        end
        s_tvalid <= 1'b0;

        while (expected_inv.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d inverses (%0d singular, %0d saturated) over three stall mixes",
                 n_checked, n_singular, n_overflow);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAILURE");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/mi3_pkg.sv
rtl/core/mi3_front.sv
rtl/core/mi3_lane.sv
rtl/core/mi3_merge.sv
rtl/core/matrix3_inverse_core.sv
bench/tb.sv
